>>> rtl/rgba_box_downsampler_macros.svh
// Assertion macros shared by the RGBA box downsampler RTL.
// Expects aclk and aresetn in scope where used.
`ifndef RGBA_BOX_DOWNSAMPLER_MACROS_SVH
`define RGBA_BOX_DOWNSAMPLER_MACROS_SVH

// same-cycle implication
`define RBDS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rbds_pkg.sv
// Package for the RGBA box downsampler: payload structs, control structs,
// register indexes, widths and the reciprocal table. No dependencies.
`timescale 1ns / 1ps

package rbds_pkg;

    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int DEFAULT_MAX_SCALE = 4;
    localparam int HEIGHT_LIMIT      = 4096;

    localparam int CHANNELS    = 4;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 24;
    localparam int NUM_W       = 25;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 31;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int SCALE_W     = 3;
    localparam int SCALE_EFF_W = 4;
    localparam int DIM_W       = 13;
    localparam int DIM_CMP_W   = 14;
    localparam int ROW_W       = 12;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = DIM_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_HEIGHT = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET  = 3'd1;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd512;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd512;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_alpha;
    } in_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              row_end;
        logic              frame_end;
    } out_pixel_t;

    typedef struct packed {
        logic capture;
        logic acc;
        logic mul;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
    } dp_status_t;

    // ceil(2^31 / (s*s)); exact floor division for numerators below 2^25
    function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_EFF_W-1:0] s);
        logic [RECIP_W-1:0] r;
        unique case (s)
            4'd2:    r = 32'd536870912;
            4'd3:    r = 32'd238609295;
            4'd4:    r = 32'd134217728;
            4'd5:    r = 32'd85899346;
            4'd6:    r = 32'd59652324;
            4'd7:    r = 32'd43826197;
            4'd8:    r = 32'd33554432;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/rgba_box_downsampler.sv
// RGBA box downsampler top level: a raster stream of source pixels in, one
// rounded block average per scale-by-scale block out. A new source pixel is taken
// only once the last is through the read-modify-write of the per-column sum RAM
// (one port each way, registered read) and, if it completes a destination block,
// the reciprocal multiply stage that divides by scale squared and the output
// register (and waits while a finished result is not taken). Result flags row_end
// and frame_end mark the last pixel of a destination row and of the frame. The
// column sum RAM is not cleared after reset; the first pixel of each block loads it.
// Configuration writes are taken in any cycle, cfg_ready is always high; write
// them only between frames. Depends on rbds_pkg, rbds_ctrl, rbds_datapath.
`timescale 1ns / 1ps

module rgba_box_downsampler #(
    parameter int MAX_WIDTH = rbds_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_SCALE = rbds_pkg::DEFAULT_MAX_SCALE
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rbds_pkg::in_pixel_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rbds_pkg::out_pixel_t             m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rbds_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rbds_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rbds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rbds_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

endmodule

>>> rtl/rbds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbds_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rbds_ctrl.sv
// Sequencing controller for the RGBA box downsampler.
// Depends on rbds_pkg and rgba_box_downsampler_macros.svh.
`timescale 1ns / 1ps
`include "rgba_box_downsampler_macros.svh"

module rbds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rbds_pkg::dp_status_t status,
    output rbds_pkg::dp_cmd_t    cmd
);
    import rbds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.acc    = 1'b1;
                state_next = status.emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `RBDS_ASSERT_NEXT(a_capture_reads, cmd.capture, state_reg == ST_READ, "accepted transaction did not start a column read")
    `RBDS_ASSERT_NEXT(a_mul_to_emit, state_reg == ST_MUL, state_reg == ST_EMIT, "multiply stage not followed by emit")
    `RBDS_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, m_valid_reg, "loaded result not presented")
    `RBDS_ASSERT_IMPLY(a_ready_only_idle, s_ready, !cmd.acc && !cmd.mul && !cmd.load_out, "input ready while datapath busy")

endmodule

>>> rtl/rbds_datapath.sv
// Datapath for the RGBA box downsampler: config registers, block counters,
// column-sum RAM read-modify-write, reciprocal divide and output register.
// Depends on rbds_pkg and rbds_ram.
`timescale 1ns / 1ps

module rbds_datapath #(
    parameter int MAX_WIDTH = rbds_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_SCALE = rbds_pkg::DEFAULT_MAX_SCALE
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rbds_pkg::dp_cmd_t                    cmd,
    output rbds_pkg::dp_status_t                 status,
    input  rbds_pkg::in_pixel_t                  s_data,
    input  logic                                 cfg_valid,
    input  logic [rbds_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rbds_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rbds_pkg::out_pixel_t                 m_data
);
    import rbds_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SUB_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int ENTRY_W = CHANNELS * SUM_W;

    logic [SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    logic [SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [COL_W-1:0] dest_col_reg, dest_col_next;
    logic [ROW_W-1:0] dest_row_reg, dest_row_next;

    logic [SCALE_EFF_W-1:0] s_eff, s_last;
    logic [DIM_CMP_W-1:0]   w_eff, w_last, h_eff, h_last;
    logic first, last_col, last_row, row_last, frame_last;

    logic [CHANNELS-1:0][CHAN_W-1:0] px_reg;
    logic                            first_reg;
    logic                            emit_reg;
    logic                            row_end_reg;
    logic                            frame_end_reg;
    logic [SCALE_EFF_W-1:0]          div_scale_reg;
    logic [COL_W-1:0]                addr_reg;

    logic [ENTRY_W-1:0]              rd_data;
    logic [CHANNELS-1:0][SUM_W-1:0]  rd_sums;
    logic [CHANNELS-1:0][SUM_W-1:0]  sum_new;
    logic [2*SCALE_EFF_W-1:0]        n_sq;
    logic [2*SCALE_EFF_W-1:0]        half;

    logic [CHANNELS-1:0][NUM_W-1:0]  num_reg;
    logic [RECIP_W-1:0]              recip_reg;
    logic [CHANNELS-1:0][PROD_W-1:0] prod_reg;
    out_pixel_t                      m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCALE:      scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_DST_WIDTH:  width_reg  <= cfg_data;
                CFG_DST_HEIGHT: height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // out-of-range settings clamp to the legal range
    always_comb begin
        priority if (scale_reg == '0) begin
            s_eff = SCALE_EFF_W'(1);
        end else if (SCALE_EFF_W'(scale_reg) > SCALE_EFF_W'(MAX_SCALE)) begin
            s_eff = SCALE_EFF_W'(MAX_SCALE);
        end else begin
            s_eff = SCALE_EFF_W'(scale_reg);
        end
        priority if (width_reg == '0) begin
            w_eff = DIM_CMP_W'(1);
        end else if (DIM_CMP_W'(width_reg) > DIM_CMP_W'(MAX_WIDTH)) begin
            w_eff = DIM_CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = DIM_CMP_W'(width_reg);
        end
        priority if (height_reg == '0) begin
            h_eff = DIM_CMP_W'(1);
        end else if (DIM_CMP_W'(height_reg) > DIM_CMP_W'(HEIGHT_LIMIT)) begin
            h_eff = DIM_CMP_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = DIM_CMP_W'(height_reg);
        end
    end

    assign s_last     = s_eff - SCALE_EFF_W'(1);
    assign w_last     = w_eff - DIM_CMP_W'(1);
    assign h_last     = h_eff - DIM_CMP_W'(1);
    assign first      = (sub_row_reg == '0) && (sub_col_reg == '0);
    assign last_col   = SCALE_EFF_W'(sub_col_reg) >= s_last;
    assign last_row   = SCALE_EFF_W'(sub_row_reg) >= s_last;
    assign row_last   = DIM_CMP_W'(dest_col_reg) >= w_last;
    assign frame_last = row_last && (DIM_CMP_W'(dest_row_reg) >= h_last);

    always_comb begin
        sub_col_next  = sub_col_reg;
        sub_row_next  = sub_row_reg;
        dest_col_next = dest_col_reg;
        dest_row_next = dest_row_reg;
        if (last_col) begin
            sub_col_next = '0;
            if (row_last) begin
                dest_col_next = '0;
                if (last_row) begin
                    sub_row_next  = '0;
                    dest_row_next = (DIM_CMP_W'(dest_row_reg) >= h_last) ? '0
                                                                         : dest_row_reg + 1'b1;
                end else begin
                    sub_row_next = sub_row_reg + 1'b1;
                end
            end else begin
                dest_col_next = dest_col_reg + 1'b1;
            end
        end else begin
            sub_col_next = sub_col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
            dest_col_reg <= '0;
            dest_row_reg <= '0;
            emit_reg     <= 1'b0;
        end else if (cmd.capture) begin
            sub_col_reg  <= sub_col_next;
            sub_row_reg  <= sub_row_next;
            dest_col_reg <= dest_col_next;
            dest_row_reg <= dest_row_next;
            emit_reg     <= last_col && last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg        <= {s_data.in_red, s_data.in_green, s_data.in_blue, s_data.in_alpha};
            first_reg     <= first;
            row_end_reg   <= row_last;
            frame_end_reg <= frame_last;
            div_scale_reg <= s_eff;
            addr_reg      <= dest_col_reg;
        end
    end

    assign status.emit = emit_reg;

    rbds_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_column_sums (
        .aclk    (aclk),
        .wr_en   (cmd.acc),
        .wr_addr (addr_reg),
        .wr_data (sum_new),
        .rd_en   (cmd.capture),
        .rd_addr (dest_col_reg),
        .rd_data (rd_data)
    );

    assign rd_sums = rd_data;
    assign n_sq    = (2*SCALE_EFF_W)'(div_scale_reg) * (2*SCALE_EFF_W)'(div_scale_reg);
    assign half    = n_sq >> 1;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            sum_new[c] = first_reg ? SUM_W'(px_reg[c]) : rd_sums[c] + SUM_W'(px_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            for (int c = 0; c < CHANNELS; c++) begin
                num_reg[c] <= NUM_W'(sum_new[c]) + NUM_W'(half);
            end
            recip_reg <= recip_of(div_scale_reg);
        end
        if (cmd.mul) begin
            for (int c = 0; c < CHANNELS; c++) begin
                prod_reg[c] <= PROD_W'(num_reg[c]) * PROD_W'(recip_reg);
            end
        end
        if (cmd.load_out) begin
            m_data_reg.out_red   <= prod_reg[3][RECIP_SHIFT +: CHAN_W];
            m_data_reg.out_green <= prod_reg[2][RECIP_SHIFT +: CHAN_W];
            m_data_reg.out_blue  <= prod_reg[1][RECIP_SHIFT +: CHAN_W];
            m_data_reg.out_alpha <= prod_reg[0][RECIP_SHIFT +: CHAN_W];
            m_data_reg.row_end   <= row_end_reg;
            m_data_reg.frame_end <= frame_end_reg;
        end
    end

    assign m_data = m_data_reg;

endmodule
